/* rtl/wind_rose_histogram_macros.svh */
// Assertion macros shared by the wind-rose histogram checkers.
`ifndef WIND_ROSE_HISTOGRAM_MACROS_SVH
`define WIND_ROSE_HISTOGRAM_MACROS_SVH

// Property checked on every clock edge outside reset.
`define WRH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define WRH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/wrh_pkg.sv */
// Package with the shared constants, types and classification functions.
`default_nettype none

package wrh_pkg;

   // Histogram geometry.
   localparam int SECTORS     = 16;
   localparam int SPEED_BINS  = 7;
   localparam int COUNT_WIDTH = 32;
   localparam int NUM_BINS    = SPEED_BINS * SECTORS;
   localparam int ADDR_W      = $clog2(NUM_BINS);
   localparam int SECTOR_W    = (SECTORS > 1) ? $clog2(SECTORS) : 1;

   // A full turn in 1/16 degree.
   localparam int FULL_TURN = 5760;

   // Field widths of the channels.
   localparam int STATION_W        = 32;
   localparam int SPEED_W          = 12;
   localparam int DIR_W            = 13;
   localparam int SPEED_BIN_W      = 3;
   localparam int SECTOR_FIELD_W   = 4;
   localparam int COUNT_FIELD_W    = 32;
   localparam int PROD_W           = DIR_W + $clog2(SECTORS) + 1;

   // Decoupling queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STATION_CODE = 1'b0,
      CSR_ANY_STATION  = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_ACCUMULATE = 1'b0,
      FUNC_READ       = 1'b1
   } func_type;

   // Upper speed limits of the bins, in 1/16 m/s.
   localparam logic signed [SPEED_W-1:0] SPEED_LIM_CALM = 12'sd0;
   localparam logic signed [SPEED_W-1:0] SPEED_LIM_2MS  = 12'sd32;
   localparam logic signed [SPEED_W-1:0] SPEED_LIM_3MS  = 12'sd48;
   localparam logic signed [SPEED_W-1:0] SPEED_LIM_5MS  = 12'sd80;
   localparam logic signed [SPEED_W-1:0] SPEED_LIM_7MS  = 12'sd112;
   localparam logic signed [SPEED_W-1:0] SPEED_LIM_9MS  = 12'sd144;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic                   count_it;
      logic [SPEED_BIN_W-1:0] speed_bin;
      logic [SECTOR_W-1:0]    sector;
   } work_type;

   function automatic logic [SPEED_BIN_W-1:0] speed_class(
      input logic signed [SPEED_W-1:0] spd
   );
      logic [SPEED_BIN_W-1:0] bin;
      priority if (spd <= SPEED_LIM_CALM) bin = 3'd0;
      else if (spd <= SPEED_LIM_2MS)      bin = 3'd1;
      else if (spd <= SPEED_LIM_3MS)      bin = 3'd2;
      else if (spd <= SPEED_LIM_5MS)      bin = 3'd3;
      else if (spd <= SPEED_LIM_7MS)      bin = 3'd4;
      else if (spd <= SPEED_LIM_9MS)      bin = 3'd5;
      else                                bin = 3'd6;
      return bin;
   endfunction

   // Sector is floor(dir * SECTORS / FULL_TURN), capped at the last sector.
   // Each boundary is an independent compare against a constant.
   function automatic logic [SECTOR_W-1:0] sector_class(input logic [DIR_W-1:0] dir);
      logic [PROD_W-1:0]   prod;
      logic [SECTOR_W-1:0] sec;
      prod = PROD_W'(dir) * PROD_W'(SECTORS);
      sec  = '0;
      for (int k = 1; k < SECTORS; k++) begin
         if (prod >= PROD_W'(k * FULL_TURN)) begin
            sec = SECTOR_W'(k);
         end
      end
      return sec;
   endfunction

   function automatic logic [ADDR_W-1:0] bin_addr(
      input logic [SPEED_BIN_W-1:0] bin,
      input logic [SECTOR_W-1:0]    sec
   );
      return ADDR_W'(bin) * ADDR_W'(SECTORS) + ADDR_W'(sec);
   endfunction

endpackage

`default_nettype wire

/* rtl/wrh_if.sv */
// Channel interfaces for sample and read items and for their results.
`default_nettype none

interface wrh_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [wrh_pkg::STATION_W-1:0]       sample_station;
   logic signed [wrh_pkg::SPEED_W-1:0]  wind_speed;
   logic [wrh_pkg::DIR_W-1:0]           wind_direction;
   logic [wrh_pkg::SPEED_BIN_W-1:0]     read_speed_bin;
   logic [wrh_pkg::SECTOR_FIELD_W-1:0]  read_sector;

   modport source (
      output valid, func, sample_station, wind_speed, wind_direction,
             read_speed_bin, read_sector,
      input  ready
   );
   modport sink (
      input  valid, func, sample_station, wind_speed, wind_direction,
             read_speed_bin, read_sector,
      output ready
   );
endinterface

interface wrh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic [wrh_pkg::COUNT_FIELD_W-1:0]   bin_count;
   logic [wrh_pkg::SPEED_BIN_W-1:0]     speed_bin_out;
   logic [wrh_pkg::SECTOR_FIELD_W-1:0]  sector_out;

   modport source (
      output valid, accepted, bin_count, speed_bin_out, sector_out,
      input  ready
   );
   modport sink (
      input  valid, accepted, bin_count, speed_bin_out, sector_out,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/wrh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wrh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/wrh_front.sv */
// Front part: configuration registers, item acceptance and classification.
`default_nettype none

module wrh_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   wrh_req_if.sink                               req,
   input  wire logic                             csr_wr_en,
   input  wire logic [wrh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wrh_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             q_ready,
   output logic                                  q_push,
   output wrh_pkg::work_type                     q_item
);

   logic [wrh_pkg::STATION_W-1:0] station_code_ff, station_code_in;
   logic                          any_station_ff, any_station_in;
   logic [wrh_pkg::SPEED_BIN_W-1:0] bin;
   logic [wrh_pkg::SECTOR_W-1:0]    sec;
   logic                            hit;

   always_comb begin
      station_code_in = station_code_ff;
      any_station_in  = any_station_ff;
      if (csr_wr_en) begin
         unique case (wrh_pkg::csr_index_type'(csr_index))
            wrh_pkg::CSR_STATION_CODE: begin
               station_code_in = wrh_pkg::STATION_W'(csr_wdata);
            end
            wrh_pkg::CSR_ANY_STATION: begin
               any_station_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_code_ff <= '0;
         any_station_ff  <= 1'b1;
      end else begin
         station_code_ff <= station_code_in;
         any_station_ff  <= any_station_in;
      end
   end

   // Read items address one bin directly; out-of-range addresses clamp.
   always_comb begin
      if (req.func == wrh_pkg::FUNC_READ) begin
         if (int'(req.read_speed_bin) > wrh_pkg::SPEED_BINS - 1) begin
            bin = wrh_pkg::SPEED_BIN_W'(wrh_pkg::SPEED_BINS - 1);
         end else begin
            bin = req.read_speed_bin;
         end
         if (int'(req.read_sector) > wrh_pkg::SECTORS - 1) begin
            sec = wrh_pkg::SECTOR_W'(wrh_pkg::SECTORS - 1);
         end else begin
            sec = wrh_pkg::SECTOR_W'(req.read_sector);
         end
         hit = 1'b0;
      end else begin
         bin = wrh_pkg::speed_class(req.wind_speed);
         sec = wrh_pkg::sector_class(req.wind_direction);
         hit = any_station_ff || (req.sample_station == station_code_ff);
      end
   end

   assign req.ready        = q_ready;
   assign q_push           = req.valid && q_ready;
   assign q_item.count_it  = hit;
   assign q_item.speed_bin = bin;
   assign q_item.sector    = sec;

endmodule

`default_nettype wire

/* rtl/wrh_queue.sv */
// Short queue of classified items between the front and the back part.
`default_nettype none

module wrh_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wrh_pkg::work_type      push_item,
   output logic                   push_ready,
   input  wire logic              pop,
   output logic                   pop_valid,
   output wrh_pkg::work_type      pop_item
);

   localparam int PTR_W = (wrh_pkg::QUEUE_DEPTH > 1) ? $clog2(wrh_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(wrh_pkg::QUEUE_DEPTH + 1);

   wrh_pkg::work_type entries_ff [wrh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(wrh_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   assign push_ready = (count_ff != CNT_W'(wrh_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/wrh_back.sv */
// Back part: counter read-modify-write, forwarding and the result register.
`default_nettype none

module wrh_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wrh_pkg::work_type  q_item,
   output logic               q_pop,
   wrh_rsp_if.source          rsp
);

   localparam int CW = wrh_pkg::COUNT_WIDTH;
   localparam int AW = wrh_pkg::ADDR_W;

   // Read stage: item whose counter is being fetched.
   logic              rd_busy_ff, rd_busy_in;
   wrh_pkg::work_type rd_item_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic              rd_known_ff;
   logic              fwd_ff;
   logic [CW-1:0]     fwd_count_ff;

   // Result register.
   logic                              out_valid_ff, out_valid_in;
   logic                              out_acc_ff;
   logic [wrh_pkg::COUNT_FIELD_W-1:0] out_count_ff;
   logic [wrh_pkg::SPEED_BIN_W-1:0]   out_bin_ff;
   logic [wrh_pkg::SECTOR_FIELD_W-1:0] out_sec_ff;

   // Written flags: a counter never written reads as zero.
   logic [wrh_pkg::NUM_BINS-1:0] written_ff, written_in;

   logic          rd_done;
   logic [AW-1:0] pop_addr;
   logic [CW-1:0] ram_rd_data;
   logic [CW-1:0] cur_count;
   logic [CW-1:0] new_count;
   logic          wr_en;
   logic          fwd_in;

   assign rd_done   = rd_busy_ff && (!out_valid_ff || rsp.ready);
   assign q_pop     = q_valid && (!rd_busy_ff || rd_done);
   assign pop_addr  = wrh_pkg::bin_addr(q_item.speed_bin, q_item.sector);
   assign cur_count = fwd_ff ? fwd_count_ff : (rd_known_ff ? ram_rd_data : '0);
   assign wr_en     = rd_done && rd_item_ff.count_it;
   assign fwd_in    = wr_en && (pop_addr == rd_addr_ff);

   always_comb begin
      new_count = cur_count;
      if (rd_item_ff.count_it && !(&cur_count)) begin
         new_count = cur_count + CW'(1);
      end
   end

   always_comb begin
      rd_busy_in = rd_busy_ff;
      if (q_pop) begin
         rd_busy_in = 1'b1;
      end else if (rd_done) begin
         rd_busy_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (rd_done) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      written_in = written_ff;
      if (wr_en) begin
         written_in[rd_addr_ff] = 1'b1;
      end
   end

   wrh_ram #(
      .WIDTH (CW),
      .DEPTH (wrh_pkg::NUM_BINS)
   ) u_counters (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_addr_ff),
      .wr_data (new_count),
      .rd_en   (q_pop),
      .rd_addr (pop_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_busy_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         rd_busy_ff   <= rd_busy_in;
         out_valid_ff <= out_valid_in;
         written_ff   <= written_in;
      end
      if (q_pop) begin
         rd_item_ff   <= q_item;
         rd_addr_ff   <= pop_addr;
         rd_known_ff  <= written_ff[pop_addr];
         fwd_ff       <= fwd_in;
         fwd_count_ff <= new_count;
      end
      if (rd_done) begin
         out_acc_ff   <= rd_item_ff.count_it;
         out_count_ff <= wrh_pkg::COUNT_FIELD_W'(new_count);
         out_bin_ff   <= rd_item_ff.speed_bin;
         out_sec_ff   <= wrh_pkg::SECTOR_FIELD_W'(rd_item_ff.sector);
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.accepted      = out_acc_ff;
   assign rsp.bin_count     = out_count_ff;
   assign rsp.speed_bin_out = out_bin_ff;
   assign rsp.sector_out    = out_sec_ff;

endmodule

`default_nettype wire

/* rtl/wind_rose_histogram.sv */
// Top level of the wind-rose histogram block.
`default_nettype none

// The block counts wind samples in a 7 by 16 grid of saturating counters,
// one per speed bin and 22.5-degree direction sector, all zero after reset.
// An accumulate item is classified on arrival: its speed picks a bin from
// the limits 0, 2, 3, 5, 7 and 9 m/s, its direction picks a sector (a
// direction past a full turn lands in the last sector), and it is counted
// only when its station code matches the configured one or any-station mode
// is on. A read item returns the count of one bin, with out-of-range bin or
// sector numbers clamped to the last one. Every item gives exactly one
// result, in order. The block sustains one item per clock cycle while the result
// side does not stall: the front part classifies an item in the cycle it is
// accepted and drops it into a two-entry queue, and the back part reads the
// counter memory when it pops an item and, for a counted sample, writes the new
// count back when the result is registered, forwarding it when the following
// item hits the same bin. An item passes the queue, the read stage with the
// memory's registered read port, and the result register before its result is
// offered; a stalled result side holds it there. The counters need no clearing
// pass after reset; a written flag per counter makes an untouched counter read
// as zero. Configuration registers are to be written through the csr port only
// while idle, which the block does not enforce; they take effect on the next item.

module wind_rose_histogram (
   input  wire logic                             clock,
   input  wire logic                             reset,
   wrh_req_if.sink                               req_ch,
   wrh_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [wrh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wrh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic              q_ready;
   logic              q_push;
   wrh_pkg::work_type q_in_item;
   logic              q_valid;
   logic              q_pop;
   wrh_pkg::work_type q_out_item;

   // Station filter, bin and sector classification.
   wrh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   // Decouples acceptance from the counter update.
   wrh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_out_item)
   );

   // Counter update and result delivery.
   wrh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_out_item),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

/* rtl/wrh_checker.sv */
// Port-level assertions for the wind-rose histogram and their binding.
`default_nettype none

`include "wind_rose_histogram_macros.svh"

module wrh_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                rsp_accepted,
   input wire logic [wrh_pkg::COUNT_FIELD_W-1:0]   rsp_bin_count,
   input wire logic [wrh_pkg::SPEED_BIN_W-1:0]     rsp_speed_bin_out
);

   // A result waiting on the consumer stays offered.
   `WRH_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")

   // Reset empties the result register.
   `WRH_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid, "result item offered after reset")

   // Classification and read clamping never yield a bin past the last one.
   `WRH_ASSERT(a_bin_range, rsp_valid |-> rsp_speed_bin_out <= 3'(wrh_pkg::SPEED_BINS - 1), "speed bin out of range")

   // A counted sample leaves its counter at one or more.
   `WRH_ASSERT(a_count_nonzero, rsp_valid && rsp_accepted |-> (wrh_pkg::COUNT_WIDTH > wrh_pkg::COUNT_FIELD_W) || (rsp_bin_count != '0), "counted sample shows zero count")

endmodule

bind wind_rose_histogram wrh_checker u_wrh_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_accepted      (rsp_ch.accepted),
   .rsp_bin_count     (rsp_ch.bin_count),
   .rsp_speed_bin_out (rsp_ch.speed_bin_out)
);

`default_nettype wire

/* test/wrh_tally_checker.sv */
// Checker that predicts every wind-rose histogram result and compares it with the block.
`timescale 1ns / 100ps

module wrh_tally_checker
   import wrh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   wrh_req_if                     req_mon,
   wrh_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   // Upper speed limits of the bins, in 1/16 m/s.
   localparam int CALM_TOP = 0;
   localparam int LIGHT_TOP = 32;
   localparam int GENTLE_TOP = 48;
   localparam int MODERATE_TOP = 80;
   localparam int FRESH_TOP = 112;
   localparam int STRONG_TOP = 144;

   typedef struct packed {
      logic                      accepted;
      logic [COUNT_FIELD_W-1:0]  bin_count;
      logic [SPEED_BIN_W-1:0]    speed_bin;
      logic [SECTOR_FIELD_W-1:0] sector;
   } rose_result_type;

   logic [COUNT_WIDTH-1:0] rose_counts [NUM_BINS];
   logic [STATION_W-1:0]   station_filter;
   logic                   any_filter;
   rose_result_type        due_results [$];
   int                     errors = 0;

   // Classifies one item, bumps the counter it hits and returns the result the block owes.
   function automatic rose_result_type tally_item(
      logic                       f,
      logic [STATION_W-1:0]       stn,
      logic signed [SPEED_W-1:0]  spd,
      logic [DIR_W-1:0]           dir,
      logic [SPEED_BIN_W-1:0]     rb,
      logic [SECTOR_FIELD_W-1:0]  rs
   );
      rose_result_type r;
      int unsigned     bin;
      int unsigned     sec;
      int unsigned     slot;
      logic            hit;
      hit = 1'b0;
      if (f == FUNC_READ) begin
         bin = (int'(rb) > SPEED_BINS - 1) ? SPEED_BINS - 1 : int'(rb);
         sec = (int'(rs) > SECTORS - 1) ? SECTORS - 1 : int'(rs);
      end else begin
         if (spd <= CALM_TOP) bin = 0;
         else if (spd <= LIGHT_TOP) bin = 1;
         else if (spd <= GENTLE_TOP) bin = 2;
         else if (spd <= MODERATE_TOP) bin = 3;
         else if (spd <= FRESH_TOP) bin = 4;
         else if (spd <= STRONG_TOP) bin = 5;
         else bin = 6;
         sec = (int'(dir) * SECTORS) / FULL_TURN;
         if (sec > SECTORS - 1) sec = SECTORS - 1;
         hit = any_filter || (stn == station_filter);
      end
      slot = bin * SECTORS + sec;
      if (slot >= NUM_BINS) slot = NUM_BINS - 1;
      if (hit && rose_counts[slot] != '1) begin
         rose_counts[slot] = rose_counts[slot] + COUNT_WIDTH'(1);
      end
      r.accepted  = hit;
      r.bin_count = COUNT_FIELD_W'(rose_counts[slot]);
      r.speed_bin = SPEED_BIN_W'(bin);
      r.sector    = SECTOR_FIELD_W'(sec);
      return r;
   endfunction

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rose_result_type want;
      if (reset) begin
         foreach (rose_counts[i]) rose_counts[i] = '0;
         station_filter = '0;
         any_filter = 1'b1;
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0b %0h %0d %0d",
                        $time, rsp_mon.accepted, rsp_mon.bin_count, rsp_mon.speed_bin_out,
                        rsp_mon.sector_out);
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("accepted", 64'(want.accepted), 64'(rsp_mon.accepted));
               check_field("bin_count", 64'(want.bin_count), 64'(rsp_mon.bin_count));
               check_field("speed_bin_out", 64'(want.speed_bin),
                           64'(rsp_mon.speed_bin_out));
               check_field("sector_out", 64'(want.sector), 64'(rsp_mon.sector_out));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            due_results.push_back(tally_item(req_mon.func, req_mon.sample_station,
                                             req_mon.wind_speed, req_mon.wind_direction,
                                             req_mon.read_speed_bin, req_mon.read_sector));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STATION_CODE: station_filter = csr_wdata[STATION_W-1:0];
               CSR_ANY_STATION:  any_filter = csr_wdata[0];
               default: ;
            endcase
         end
      end
      fail_count    <= errors;
      pending_count <= due_results.size();
   end

endmodule

/* test/tb_top.sv */
// Top of the wind-rose histogram testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import wrh_pkg::*;

   // Cycles without any accepted item before the run is declared hung.
   localparam int IDLE_LIMIT = 1000;
   // Random items per filter setting.
   localparam int PHASE_ITEMS = 145;
   localparam int PHASES = 5;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wrh_req_if req_ch ();
   wrh_rsp_if rsp_ch ();

   int fail_count;
   int pending_count;
   int idle_cycles;

   // Idling switches for the sender and for the result side.
   bit send_gaps_on;
   bit rsp_stalls_on;

   // The station code currently programmed, so that half the samples can match it.
   logic [STATION_W-1:0] station_now;

   // Speeds right at the bin limits, and a few hot spots that keep hitting the same bins.
   int speed_edges [6] = '{0, 32, 48, 80, 112, 144};
   int hot_speeds [3] = '{16, 40, 100};
   int hot_dirs [2] = '{100, 3000};
   int hot_bins [3] = '{1, 2, 4};
   int hot_sectors [2] = '{0, 8};

   wind_rose_histogram dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wrh_tally_checker u_tally (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The result side takes results freely, or holds ready low for random bursts
   // while stalls are enabled.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: the run is hung when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one item and returns at the edge that accepts it. Valid stays high into the
   // next item unless a random gap follows, so it is never lowered and raised in one step.
   task automatic send_item(
      func_type                   f,
      logic [STATION_W-1:0]       stn,
      logic signed [SPEED_W-1:0]  spd,
      logic [DIR_W-1:0]           dir,
      logic [SPEED_BIN_W-1:0]     rb,
      logic [SECTOR_FIELD_W-1:0]  rs
   );
      req_ch.valid          <= 1'b1;
      req_ch.func           <= f;
      req_ch.sample_station <= stn;
      req_ch.wind_speed     <= spd;
      req_ch.wind_direction <= dir;
      req_ch.read_speed_bin <= rb;
      req_ch.read_sector    <= rs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (send_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every item has produced its result. The first edge lets
   // the count take in an item that was accepted at the current edge.
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Reprograms the station filter once the block has gone idle.
   task automatic set_filter(logic [STATION_W-1:0] code, logic any);
      drain();
      csr_write(CSR_STATION_CODE, code);
      csr_write(CSR_ANY_STATION, CSR_DATA_W'(any));
      station_now = code;
   endtask

   // One random item. Half carry the programmed station; some have speeds or directions
   // near the bin and sector borders; about a third go to a few hot bins so that repeated
   // hits and reads of freshly counted bins come often.
   task automatic send_random;
      func_type                  f;
      logic [STATION_W-1:0]      stn;
      logic signed [SPEED_W-1:0] spd;
      logic [DIR_W-1:0]          dir;
      logic [SPEED_BIN_W-1:0]    rb;
      logic [SECTOR_FIELD_W-1:0] rs;
      int                        k;
      bit                        hot;
      f   = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_ACCUMULATE;
      hot = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 3))
         0, 1: stn = station_now;
         2: stn = station_now ^ (32'd1 << $urandom_range(0, 31));
         default: stn = $urandom();
      endcase
      case ($urandom_range(0, 4))
         0: spd = SPEED_W'($urandom());
         1: spd = SPEED_W'(speed_edges[$urandom_range(0, 5)] + int'($urandom_range(0, 2)) - 1);
         default: spd = SPEED_W'($urandom_range(0, 170));
      endcase
      case ($urandom_range(0, 4))
         // Anywhere in the field, past a full turn included.
         0: dir = DIR_W'($urandom());
         1: begin
            k = $urandom_range(1, 16);
            dir = DIR_W'(k * 360 + int'($urandom_range(0, 2)) - 1);
         end
         default: dir = DIR_W'($urandom_range(0, FULL_TURN - 1));
      endcase
      rb = SPEED_BIN_W'($urandom());
      rs = SECTOR_FIELD_W'($urandom());
      if (hot) begin
         spd = SPEED_W'(hot_speeds[$urandom_range(0, 2)]);
         dir = DIR_W'(hot_dirs[$urandom_range(0, 1)]);
         rb  = SPEED_BIN_W'(hot_bins[$urandom_range(0, 2)]);
         rs  = SECTOR_FIELD_W'(hot_sectors[$urandom_range(0, 1)]);
      end
      send_item(f, stn, spd, dir, rb, rs);
   endtask

   initial begin
      logic [STATION_W-1:0] code;
      logic                 any;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_STATION_CODE;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.func           <= FUNC_ACCUMULATE;
      req_ch.sample_station <= '0;
      req_ch.wind_speed     <= '0;
      req_ch.wind_direction <= '0;
      req_ch.read_speed_bin <= '0;
      req_ch.read_sector    <= '0;
      station_now   = '0;
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset filter, where every station is taken. Speeds sit on
      // both sides of each bin limit, directions on sector borders and past a full turn.
      send_item(FUNC_ACCUMULATE, 32'h0000_0000, 12'sh800, 13'd0, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h0000_0000, 12'sd0, 13'd359, 3'd7, 4'd15);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd1, 13'd360, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd32, 13'd5759, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd33, 13'd5760, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd48, 13'd8191, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd49, 13'd2880, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd80, 13'd2879, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd81, 13'd719, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd112, 13'd720, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd113, 13'd4000, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd144, 13'd4000, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd145, 13'd100, 3'd0, 4'd0);
      // The same bin three times in a row exercises the count forwarding.
      send_item(FUNC_ACCUMULATE, 32'h1234_5678, 12'sd2047, 13'd100, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'hFFFF_FFFF, 12'sd2047, 13'd100, 3'd0, 4'd0);
      // Reads ignore the sample fields; a bin number past the last one is clamped.
      send_item(FUNC_READ, $urandom(), SPEED_W'($urandom()), DIR_W'($urandom()), 3'd6, 4'd0);
      send_item(FUNC_READ, $urandom(), SPEED_W'($urandom()), DIR_W'($urandom()), 3'd7, 4'd15);
      send_item(FUNC_READ, $urandom(), SPEED_W'($urandom()), DIR_W'($urandom()), 3'd0, 4'd0);
      send_item(FUNC_READ, $urandom(), SPEED_W'($urandom()), DIR_W'($urandom()), 3'd2, 4'd15);

      // With the filter on, a sample from another station is rejected and leaves the count.
      set_filter(32'hA5A5_0F0F, 1'b0);
      send_item(FUNC_ACCUMULATE, 32'hA5A5_0F0F, 12'sd40, 13'd1000, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'hA5A5_0F0E, 12'sd40, 13'd1000, 3'd0, 4'd0);
      send_item(FUNC_ACCUMULATE, 32'h0000_0000, 12'sd40, 13'd1000, 3'd0, 4'd0);
      send_item(FUNC_READ, 32'hA5A5_0F0F, 12'sd40, 13'd1000, 3'd2, 4'd2);

      // Random phases, each under its own filter setting, the code extremes among them.
      // The last phase runs with no idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin code = $urandom(); any = 1'b0; end
            1: begin code = 32'h0000_0000; any = 1'b0; end
            2: begin code = 32'hFFFF_FFFF; any = 1'b0; end
            3: begin code = $urandom(); any = 1'b1; end
            default: begin code = $urandom(); any = 1'b0; end
         endcase
         set_filter(code, any);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Stretches of full-rate traffic come between the idling ones.
            send_gaps_on  = (p != PHASES - 1) && ((i % 50) < 35);
            rsp_stalls_on = send_gaps_on;
            send_random();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/wrh_pkg.sv
rtl/wrh_if.sv
rtl/wrh_ram.sv
rtl/wrh_front.sv
rtl/wrh_queue.sv
rtl/wrh_back.sv
rtl/wind_rose_histogram.sv
rtl/wrh_checker.sv
test/wrh_tally_checker.sv
test/tb_top.sv
